@@ design/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the slider/time scaler
// Holds the time width, the slider range, the action codes and the
// operand bundle that flows through the multiply-divide pipeline.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int TIME_BITS  = 48;
	// Time fields on the ports are 48 bits; only the low TIME_BITS of them matter.
	localparam int TW         = (TIME_BITS < 48) ? TIME_BITS : 48;
	localparam int SLIDER_MAX = 1000;
	localparam int SLIDER_MIN = 0;
	localparam int SW         = 16;

	localparam logic ACT_T2S = 1'b0;
	localparam logic ACT_S2T = 1'b1;

	// Operands of floor(a * b / c) with a < c, plus the running remainder
	// and quotient. When run is low, q already holds the final answer.
	typedef struct packed {
		logic          act;
		logic          run;
		logic [TW-1:0] a;
		logic [TW-1:0] c;
		logic [TW-1:0] gap;
		logic [TW-1:0] b;
		logic [TW-1:0] r;
		logic [TW-1:0] q;
	} op_t;

endpackage

@@ design/sts_mdiv_stage.sv @@
// ----------------------------------------------------------------------------
// sts_mdiv_stage: one bit of the restoring multiply-divide
// Consumes the top multiplier bit: double the remainder, then add the
// multiplicand if the bit is set, reducing modulo the divisor each time.
// ----------------------------------------------------------------------------
module sts_mdiv_stage
	import sts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  op_t  in_op,
	output logic out_vld,
	output op_t  out_op
);

	logic          vld_s1;
	op_t           op_s1;
	op_t           nxt;
	logic [TW:0]   dbl;
	logic [TW:0]   dif;
	logic          ge1;
	logic          ge2;
	logic [TW-1:0] r1;
	logic [TW-1:0] q1;
	logic [TW-1:0] r2;
	logic [TW-1:0] q2;

	always_comb begin
		dbl = {in_op.r, 1'b0};
		dif = dbl - {1'b0, in_op.c};
		ge1 = (dbl >= {1'b0, in_op.c});
		r1  = ge1 ? dif[TW-1:0] : dbl[TW-1:0];
		q1  = {in_op.q[TW-2:0], ge1};
		// add step: r1 + a wraps past c exactly when r1 >= c - a
		ge2 = (r1 >= in_op.gap);
		r2  = ge2 ? (r1 - in_op.gap) : (r1 + in_op.a);
		q2  = q1 + TW'(ge2);

		nxt   = in_op;
		nxt.b = {in_op.b[TW-2:0], 1'b0};
		if (in_op.run) begin
			if (in_op.b[TW-1]) begin
				nxt.r = r2;
				nxt.q = q2;
			end else begin
				nxt.r = r1;
				nxt.q = q1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_op  = op_s1;

endmodule

@@ design/slider_time_scaler_top.sv @@
// ----------------------------------------------------------------------------
// slider_time_scaler_top: playback time <-> slider position converter
// Stateless converter; every input transfer yields one output transfer.
// ----------------------------------------------------------------------------
// Accepts one item per clock when the output side never stalls. The
// multiply-divide pipeline resolves one multiplier bit per register
// stage: a decode stage, TW bit stages and the output register. Both
// directions share that pipeline as floor(a*b/c) with a < c: time to
// slider uses a = position, b = SLIDER_MAX, c = duration; slider to time
// uses a = clamped slider, b = duration, c = SLIDER_MAX. Zero duration or
// position, position at or past the duration, and a slider at SLIDER_MAX
// skip the arithmetic and carry their answer straight through.
// Backpressure stalls only the stages in front of a full stage, so
// bubbles collapse and a waiting result does not block new transfers
// while empty stages remain.
// ----------------------------------------------------------------------------
module slider_time_scaler_top
	import sts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // slider_in[31:0], position_in_ms[79:32], track_length_ms[127:80]
	input  logic         s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata   // slider_out[15:0], time_out_ms[63:16]
);

	localparam logic [TW-1:0] SMAX_T = TW'(SLIDER_MAX);

	// Decode of the incoming transfer
	logic signed [31:0] sl;
	logic [TW-1:0]      pos;
	logic [TW-1:0]      dur;
	logic [SW-1:0]      v;
	logic [TW-1:0]      gap_t2s;
	logic [TW-1:0]      gap_s2t;
	op_t                dec;

	// Pipeline: index 0 is the decode register, 1..TW the bit stages
	logic               vld_s1;
	op_t                op_s1;
	logic [TW:0]        eng_vld;
	op_t                eng_op [0:TW];
	logic [TW+1:0]      adv;

	logic               out_vld_q;
	logic [63:0]        out_data_q;

	always_comb begin
		sl  = $signed(s_tdata[31:0]);
		pos = s_tdata[32 +: TW];
		dur = s_tdata[80 +: TW];

		// clamp slider to the valid range
		if (sl < SLIDER_MIN) begin
			v = SW'(SLIDER_MIN);
		end else if (sl > SLIDER_MAX) begin
			v = SW'(SLIDER_MAX);
		end else begin
			v = sl[SW-1:0];
		end

		// both differences in parallel, selected below
		gap_t2s = dur - pos;
		gap_s2t = SMAX_T - TW'(v);

		dec     = '0;
		dec.act = s_tuser;
		if (s_tuser == ACT_T2S) begin
			dec.a   = pos;
			dec.b   = SMAX_T;
			dec.c   = dur;
			dec.gap = gap_t2s;
			if (dur == '0 || pos == '0) begin
				dec.q = TW'(SLIDER_MIN);
			end else if (pos >= dur) begin
				dec.q = SMAX_T;
			end else begin
				dec.run = 1'b1;
			end
		end else begin
			dec.a   = TW'(v);
			dec.b   = dur;
			dec.c   = SMAX_T;
			dec.gap = gap_s2t;
			if (TW'(v) == SMAX_T) begin
				// full scale: the answer is the duration itself
				dec.q = dur;
			end else begin
				dec.run = 1'b1;
			end
		end
	end

	// Ready ripples back: a stage advances if it is empty or the next one advances
	assign adv[TW+1] = ~out_vld_q | m_tready;

	genvar k;
	generate
		for (k = 0; k <= TW; k++) begin : g_adv
			assign adv[k] = ~eng_vld[k] | adv[k+1];
		end
	endgenerate

	assign s_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv[0]) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			op_s1 <= dec;
		end
	end

	assign eng_vld[0] = vld_s1;
	assign eng_op[0]  = op_s1;

	// One multiplier bit per stage, most significant first
	generate
		for (k = 1; k <= TW; k++) begin : g_bit
			sts_mdiv_stage u_stage (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (adv[k]),
				.in_vld  (eng_vld[k-1]),
				.in_op   (eng_op[k-1]),
				.out_vld (eng_vld[k]),
				.out_op  (eng_op[k])
			);
		end
	endgenerate

	// Output register: route the quotient to the field of its direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv[TW+1]) begin
			out_vld_q <= eng_vld[TW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[TW+1]) begin
			if (eng_op[TW].act == ACT_T2S) begin
				out_data_q <= {48'd0, eng_op[TW].q[SW-1:0]};
			end else begin
				out_data_q <= {48'(eng_op[TW].q), 16'd0};
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	// A slider result never leaves the slider range
	a_slider_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] <= 16'(SLIDER_MAX)))
		else $error("slider result above maximum");

	// Only one of the two result fields may be nonzero
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] == 16'd0 || m_tdata[63:16] == 48'd0))
		else $error("both result fields nonzero");

	// With the output register empty the pipeline must take new transfers
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");
`endif

endmodule

@@ dv/slider_time_scaler_top_tb.sv @@
// ----------------------------------------------------------------------------
// slider_time_scaler_top_tb: self-checking bench for the time/slider scaler
// Drives time-to-slider and slider-to-time transfers with random gaps on
// both sides and checks every result against a local scaling predictor.
// ----------------------------------------------------------------------------
module slider_time_scaler_top_tb
	import sts_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// One predicted result, laid out as on m_tdata.
	typedef struct packed {
		logic [47:0] time_ms;
		logic [15:0] slider_pos;
	} scaled_t;

	localparam logic [47:0] TIME_ALL_ONES = '1;
	localparam int          MAX_GAP       = 16;
	localparam int          DRAIN_CYCLES  = 60;  // pipeline is TW + 2 deep

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;  // slider_in[31:0], position_in_ms[79:32],
	                              // track_length_ms[127:80]
	logic         s_tuser  = 1'b0;  // action
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;  // slider_out[15:0], time_out_ms[63:16]

	// Results predicted for accepted transfers, oldest first.
	scaled_t scaled_q[$];
	scaled_t oldest_scaled;
	int      mismatches  = 0;
	int      sent_count  = 0;
	bit      src_steady  = 1'b0;  // when set the source sends back to back
	bit      sink_steady = 1'b0;  // when set the sink never stalls

	slider_time_scaler_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scale one request the way the block should: time to slider is
	// floor(pos * SLIDER_MAX / dur) with its zero and saturation shortcuts,
	// slider to time is floor(dur * v / SLIDER_MAX) for the clamped slider v.
	function automatic scaled_t scale_request(input logic act, input logic [31:0] slider,
			input logic [47:0] pos, input logic [47:0] dur);
		scaled_t     res;
		logic [63:0] smax;
		logic [63:0] v;
		logic [63:0] whole;
		logic [63:0] rem;
		logic [63:0] t;
		int signed   s;
		res  = '0;
		smax = 64'(SLIDER_MAX);
		if (act == ACT_T2S) begin
			if (dur == '0 || pos == '0) begin
				res.slider_pos = 16'(SLIDER_MIN);
			end else if (pos >= dur) begin
				res.slider_pos = 16'(SLIDER_MAX);
			end else begin
				t = ({16'b0, pos} * smax) / {16'b0, dur};
				res.slider_pos = t[15:0];
			end
		end else begin
			s = signed'(slider);
			if (s < SLIDER_MIN) begin
				s = SLIDER_MIN;
			end
			if (s > SLIDER_MAX) begin
				s = SLIDER_MAX;
			end
			v     = 64'(s);
			whole = {16'b0, dur} / smax;
			rem   = {16'b0, dur} % smax;
			t     = whole * v + (rem * v) / smax;
			res.time_ms = t[47:0];
		end
		return res;
	endfunction

	// Random time value of at most the given number of significant bits.
	function automatic logic [47:0] rand_time(input int bits);
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		if (bits <= 0) begin
			return '0;
		end
		return raw[47:0] & ((48'h1 << bits) - 48'h1);
	endfunction

	task automatic flag_error(input string msg);
		if (mismatches < 10) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// Send one request: idle for a random gap, present the transfer, hold it
	// until the block takes it, then record the predicted result.
	task automatic send_item(input logic act, input logic [31:0] slider,
			input logic [47:0] pos, input logic [47:0] dur);
		int gap;
		if (sent_count % 32 == 0) begin
			src_steady = ($urandom_range(0, 3) == 0);
		end
		gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {dur, pos, slider};
		do @(posedge clk); while (!s_tready);
		scaled_q.push_back(scale_request(act, slider, pos, dur));
		sent_count++;
	endtask

	// Time to slider: unknown duration, zero position, position at and past
	// the duration, and the widest operands just below the duration.
	task automatic test_time_to_slider_edges();
		send_item(ACT_T2S, $urandom, 48'd0, 48'd0);
		send_item(ACT_T2S, $urandom, TIME_ALL_ONES, 48'd0);
		send_item(ACT_T2S, $urandom, 48'd0, TIME_ALL_ONES);
		send_item(ACT_T2S, $urandom, 48'd12345, 48'd12345);
		send_item(ACT_T2S, $urandom, TIME_ALL_ONES, 48'd1);
		send_item(ACT_T2S, $urandom, TIME_ALL_ONES - 48'd1, TIME_ALL_ONES);
		send_item(ACT_T2S, $urandom, 48'd1, TIME_ALL_ONES);
		send_item(ACT_T2S, $urandom, 48'd1, 48'd2);
		send_item(ACT_T2S, $urandom, 48'd333, 48'd1000);
		send_item(ACT_T2S, $urandom, 48'h8000_0000_0000, TIME_ALL_ONES);
	endtask

	// Slider to time: clamping on both sides, the range ends, unknown
	// duration and durations below SLIDER_MAX.
	task automatic test_slider_to_time_edges();
		send_item(ACT_S2T, 32'h8000_0000, rand_time(48), TIME_ALL_ONES);
		send_item(ACT_S2T, 32'hFFFF_FFFF, rand_time(48), 48'd5000);
		send_item(ACT_S2T, 32'd0, rand_time(48), TIME_ALL_ONES);
		send_item(ACT_S2T, 32'd1, rand_time(48), TIME_ALL_ONES);
		send_item(ACT_S2T, 32'(SLIDER_MAX - 1), rand_time(48), TIME_ALL_ONES);
		send_item(ACT_S2T, 32'(SLIDER_MAX), rand_time(48), TIME_ALL_ONES);
		send_item(ACT_S2T, 32'(SLIDER_MAX + 1), rand_time(48), 48'd777);
		send_item(ACT_S2T, 32'h7FFF_FFFF, rand_time(48), 48'd12345);
		send_item(ACT_S2T, 32'd500, rand_time(48), 48'd0);
		send_item(ACT_S2T, 32'(SLIDER_MAX), rand_time(48), 48'd0);
		send_item(ACT_S2T, 32'(SLIDER_MAX - 1), rand_time(48), 48'd999);
		send_item(ACT_S2T, 32'd1, rand_time(48), 48'd999);
	endtask

	// Mixed random traffic. Most requests land in the arithmetic path
	// (position below duration, slider inside its range); the rest hit the
	// shortcuts and the clamps. Durations span every width.
	task automatic test_random_mix(input int count);
		logic [47:0] dur;
		logic [47:0] pos;
		logic [31:0] slider;
		int          pick;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 1) == 0) begin
				dur    = rand_time($urandom_range(1, 48));
				slider = $urandom;
				case (pick)
					0: pos = '0;
					1: pos = dur;
					2: pos = dur + rand_time($urandom_range(0, 48));
					3: begin
						pos = rand_time(48);
						dur = '0;
					end
					default: pos = (dur == '0) ? rand_time(48) : rand_time(48) % dur;
				endcase
				send_item(ACT_T2S, slider, pos, dur);
			end else begin
				dur = rand_time($urandom_range(0, 48));
				pos = rand_time(48);
				case (pick)
					7: slider = ($urandom_range(0, 1) == 0) ? 32'(SLIDER_MAX) : 32'(SLIDER_MIN);
					8: slider = $urandom;
					9: slider = $urandom | 32'h8000_0000;
					default: slider = $urandom_range(0, SLIDER_MAX);
				endcase
				send_item(ACT_S2T, slider, pos, dur);
			end
		end
	endtask

	// Sink: stall for a random number of cycles before each result, with
	// stretches of full readiness, and hold tready until a transfer happens.
	initial begin
		int stall;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			if (taken % 32 == 0) begin
				sink_steady = ($urandom_range(0, 3) == 0);
			end
			stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
		end
	end

	// Check each output transfer against the oldest pending prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (scaled_q.size() == 0) begin
				flag_error($sformatf("unexpected result slider=%0d time=%0d",
					m_tdata[15:0], m_tdata[63:16]));
			end else begin
				oldest_scaled = scaled_q.pop_front();
				if (m_tdata[15:0] !== oldest_scaled.slider_pos ||
						m_tdata[63:16] !== oldest_scaled.time_ms) begin
					flag_error($sformatf("slider exp %0d got %0d, time exp %0d got %0d",
						oldest_scaled.slider_pos, m_tdata[15:0],
						oldest_scaled.time_ms, m_tdata[63:16]));
				end
			end
		end
	end

	// Hold reset, run the tests in turn, drain the pipeline and report.
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_time_to_slider_edges();
		test_slider_to_time_edges();
		test_random_mix(400);
		s_tvalid <= 1'b0;
		while (scaled_q.size() != 0) begin
			@(posedge clk);
		end
		// Let any stray result show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && scaled_q.size() == 0) begin
			$display("** slider_time_scaler_top: PASSED **");
		end else begin
			$display("** slider_time_scaler_top: FAILED **");
		end
		$finish;
	end

	// Watchdog: fails the run if it has not finished by the time limit.
	initial begin
		#2_000_000;
		$display("** slider_time_scaler_top: FAILED **");
		$finish;
	end

endmodule
